### hw/rtl/rhe_pkg.sv
// ----------------------------------------------------------------------------
// rhe_pkg: shared types and constants of the RGB histogram equalizer
// Command codes, sizes and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package rhe_pkg;

  localparam int BIN_COUNT  = 256;
  localparam int COUNT_BITS = 22;
  localparam int BIN_BITS   = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int PIX_BITS   = 8;
  // cum*255 needs COUNT_BITS+8 bits; quotient up to 255 plus clamp headroom
  localparam int PROD_BITS  = COUNT_BITS + 8;
  localparam int QUO_BITS   = 9;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_ACCUM = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_MAP   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_MAP_RD,
    ST_MAP_OUT,
    ST_CLR,
    ST_BLD_RD,
    ST_BLD_SUM,
    ST_BLD_DIV,
    ST_BLD_WR,
    ST_OUT_WAIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;   // capture input pixel
    logic acc_write;  // write incremented bins, bump pixel count
    logic clr_start;  // reset sweep index
    logic clr_write;  // write zero at sweep index, advance
    logic bld_start;  // reset bin index and running sums
    logic bld_read;   // read bins at bin index
    logic bld_sum;    // add bins into running sums, start divider
    logic div_step;   // one divider bit
    logic bld_write;  // write tables, advance bin index
    logic out_load;   // load output register from table read data
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;  // index is at last bin
    logic div_done;    // divider finished
    logic out_full;    // output register holds a beat the receiver is not taking
  } stat_t;

endpackage

### hw/rtl/rhe_ctrl.sv
// ----------------------------------------------------------------------------
// rhe_ctrl: command sequencer
// Decodes one command beat and steps the datapath through its passes.
// ----------------------------------------------------------------------------
module rhe_ctrl import rhe_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_fire,
  input  cmd_t  in_cmd,
  input  stat_t stat,
  output logic  busy,
  output ctrl_t ctrl
);

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_cmd)
            CMD_ACCUM: state_nxt = ST_ACC_RD;
            CMD_BUILD: state_nxt = ST_BLD_RD;
            CMD_MAP:   state_nxt = ST_MAP_RD;
            CMD_CLEAR: state_nxt = ST_CLR;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ACC_RD:   state_nxt = ST_ACC_WR;
      ST_ACC_WR:   state_nxt = ST_IDLE;
      ST_MAP_RD:   state_nxt = stat.out_full ? ST_OUT_WAIT : ST_MAP_OUT;
      ST_OUT_WAIT: state_nxt = stat.out_full ? ST_OUT_WAIT : ST_MAP_OUT;
      ST_MAP_OUT:  state_nxt = ST_IDLE;
      ST_CLR:      state_nxt = stat.sweep_last ? ST_IDLE : ST_CLR;
      ST_BLD_RD:   state_nxt = ST_BLD_SUM;
      ST_BLD_SUM:  state_nxt = ST_BLD_DIV;
      ST_BLD_DIV:  state_nxt = stat.div_done ? ST_BLD_WR : ST_BLD_DIV;
      ST_BLD_WR:   state_nxt = stat.sweep_last ? ST_IDLE : ST_BLD_RD;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        ctrl.latch_in  = in_fire;
        ctrl.clr_start = in_fire && (in_cmd == CMD_CLEAR);
        ctrl.bld_start = in_fire && (in_cmd == CMD_BUILD);
      end
      ST_ACC_WR:  ctrl.acc_write = 1'b1;
      ST_MAP_OUT: ctrl.out_load  = 1'b1;
      ST_CLR:     ctrl.clr_write = 1'b1;
      ST_BLD_RD:  ctrl.bld_read  = 1'b1;
      ST_BLD_SUM: ctrl.bld_sum   = 1'b1;
      ST_BLD_DIV: ctrl.div_step  = 1'b1;
      ST_BLD_WR:  ctrl.bld_write = 1'b1;
      default: ;
    endcase
  end

  // reset starts a clearing sweep of the bin memories
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLR;
    else        state_r <= state_nxt;
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctrl.acc_write, ctrl.clr_write, ctrl.bld_write, ctrl.out_load}))
    else $error("several datapath writes at once");
  a_no_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !ctrl.latch_in) else $error("beat taken while busy");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |-> !stat.out_full) else $error("output overwritten");

endmodule

### hw/rtl/rhe_dp.sv
// ----------------------------------------------------------------------------
// rhe_dp: histogram and table datapath
// Bin memories, pixel counter, running sums, serial divider, tables, output.
// ----------------------------------------------------------------------------
module rhe_dp import rhe_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_t               ctrl,
  input  logic [PIX_BITS-1:0] blue_in,
  input  logic [PIX_BITS-1:0] green_in,
  input  logic [PIX_BITS-1:0] red_in,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [PIX_BITS-1:0] blue_out,
  output logic [PIX_BITS-1:0] green_out,
  output logic [PIX_BITS-1:0] red_out,
  output stat_t               stat
);

  logic [COUNT_BITS-1:0] bb_mem [BIN_COUNT];
  logic [COUNT_BITS-1:0] gb_mem [BIN_COUNT];
  logic [COUNT_BITS-1:0] rb_mem [BIN_COUNT];
  logic [PIX_BITS-1:0]   bt_mem [BIN_COUNT];
  logic [PIX_BITS-1:0]   gt_mem [BIN_COUNT];
  logic [PIX_BITS-1:0]   rt_mem [BIN_COUNT];

  logic [BIN_BITS-1:0]   bi_r, gi_r, ri_r, idx_r;
  logic [COUNT_BITS-1:0] bq_r, gq_r, rq_r;        // bin read data
  logic [PIX_BITS-1:0]   bt_r, gt_r, rt_r;        // table read data
  logic [COUNT_BITS-1:0] pix_r;
  logic [COUNT_BITS-1:0] bc_r, gc_r, rc_r;        // running sums
  logic [PROD_BITS-1:0]  brem_r, grem_r, rrem_r;  // dividend/remainder
  logic [QUO_BITS-1:0]   bquo_r, gquo_r, rquo_r;
  logic [3:0]            dcnt_r;
  logic                  ov_r;

  // map a pixel value to its bin, clamping to the last bin
  function automatic logic [BIN_BITS-1:0] bin_of(input logic [PIX_BITS-1:0] v);
    if ({24'd0, v} > 32'(BIN_COUNT - 1)) return BIN_BITS'(BIN_COUNT - 1);
    return BIN_BITS'(v);
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [COUNT_BITS-1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
  endfunction

  // dividend cum*255 = (cum<<8) - cum
  function automatic logic [PROD_BITS-1:0] x255(input logic [COUNT_BITS-1:0] c);
    return {c, 8'd0} - PROD_BITS'(c);
  endfunction

  // restoring divide step on the top quotient window
  function automatic logic [PROD_BITS-1:0] dstep_rem(input logic [PROD_BITS-1:0] r,
                                                     input logic [COUNT_BITS-1:0] d,
                                                     input logic [3:0] k);
    logic [PROD_BITS+QUO_BITS-1:0] sd;
    sd = {{(PROD_BITS+QUO_BITS-COUNT_BITS){1'b0}}, d} << k;
    if ({{QUO_BITS{1'b0}}, r} >= sd) return r - PROD_BITS'(sd);
    return r;
  endfunction

  function automatic logic dstep_bit(input logic [PROD_BITS-1:0] r,
                                     input logic [COUNT_BITS-1:0] d,
                                     input logic [3:0] k);
    logic [PROD_BITS+QUO_BITS-1:0] sd;
    sd = {{(PROD_BITS+QUO_BITS-COUNT_BITS){1'b0}}, d} << k;
    return {{QUO_BITS{1'b0}}, r} >= sd;
  endfunction

  // quotient to table value: clamp, zero on empty histogram
  function automatic logic [PIX_BITS-1:0] qval(input logic [QUO_BITS-1:0] q,
                                               input logic ovf, input logic zero);
    if (zero) return '0;
    if (ovf || q[QUO_BITS-1]) return '1;
    return q[PIX_BITS-1:0];
  endfunction

  logic [BIN_BITS-1:0] ba, ga, ra;
  logic                pix_zero, q_ovf;
  assign pix_zero = (pix_r == '0);
  // overflow flag ov_r, cleared when the running sums are updated
  assign q_ovf = ov_r;

  // address select for bin memories
  always_comb begin
    if (ctrl.bld_read || ctrl.bld_write) begin
      ba = idx_r; ga = idx_r; ra = idx_r;
    end else begin
      ba = bi_r; ga = gi_r; ra = ri_r;
    end
  end

  // input capture and sweep index
  always_ff @(posedge clk) begin
    if (ctrl.latch_in) begin
      bi_r <= bin_of(blue_in);
      gi_r <= bin_of(green_in);
      ri_r <= bin_of(red_in);
    end
    if (!rst_n || ctrl.clr_start || ctrl.bld_start) idx_r <= '0;
    else if (ctrl.clr_write || ctrl.bld_write) idx_r <= idx_r + 1'b1;
  end

  // bin memories: one read, one write per cycle
  always_ff @(posedge clk) begin
    bq_r <= bb_mem[ba];
    gq_r <= gb_mem[ga];
    rq_r <= rb_mem[ra];
    if (ctrl.clr_write) begin
      bb_mem[idx_r] <= '0;
      gb_mem[idx_r] <= '0;
      rb_mem[idx_r] <= '0;
    end else if (ctrl.acc_write) begin
      bb_mem[bi_r] <= sat_inc(bq_r);
      gb_mem[gi_r] <= sat_inc(gq_r);
      rb_mem[ri_r] <= sat_inc(rq_r);
    end
  end

  // table memories
  always_ff @(posedge clk) begin
    bt_r <= bt_mem[bi_r];
    gt_r <= gt_mem[gi_r];
    rt_r <= rt_mem[ri_r];
    if (ctrl.bld_write) begin
      bt_mem[idx_r] <= qval(bquo_r, q_ovf, pix_zero);
      gt_mem[idx_r] <= qval(gquo_r, q_ovf, pix_zero);
      rt_mem[idx_r] <= qval(rquo_r, q_ovf, pix_zero);
    end
  end

  // pixel counter
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr_start) pix_r <= '0;
    else if (ctrl.acc_write)      pix_r <= sat_inc(pix_r);
  end

  // running sums and serial divider, one quotient bit per cycle
  logic [COUNT_BITS-1:0] bcn, gcn, rcn;
  assign bcn = sat_add(bc_r, bq_r);
  assign gcn = sat_add(gc_r, gq_r);
  assign rcn = sat_add(rc_r, rq_r);

  always_ff @(posedge clk) begin
    if (ctrl.bld_start) begin
      bc_r <= '0; gc_r <= '0; rc_r <= '0;
    end else if (ctrl.bld_sum) begin
      bc_r   <= bcn;  gc_r   <= gcn;  rc_r   <= rcn;
      brem_r <= x255(bcn); grem_r <= x255(gcn); rrem_r <= x255(rcn);
      bquo_r <= '0; gquo_r <= '0; rquo_r <= '0;
      dcnt_r <= 4'(QUO_BITS - 1);
      ov_r   <= 1'b0;
    end else if (ctrl.div_step) begin
      brem_r <= dstep_rem(brem_r, pix_r, dcnt_r);
      grem_r <= dstep_rem(grem_r, pix_r, dcnt_r);
      rrem_r <= dstep_rem(rrem_r, pix_r, dcnt_r);
      bquo_r <= {bquo_r[QUO_BITS-2:0], dstep_bit(brem_r, pix_r, dcnt_r)};
      gquo_r <= {gquo_r[QUO_BITS-2:0], dstep_bit(grem_r, pix_r, dcnt_r)};
      rquo_r <= {rquo_r[QUO_BITS-2:0], dstep_bit(rrem_r, pix_r, dcnt_r)};
      dcnt_r <= dcnt_r - 1'b1;
    end
  end
  // cum <= pix always since cum is the sum of bins each counted in pix,
  // unless saturation; quotient <= 255 then fits 9 bits, no overflow path
  assign stat.div_done   = ctrl.div_step && (dcnt_r == '0);
  assign stat.sweep_last = (idx_r == BIN_BITS'(BIN_COUNT - 1));
  assign stat.out_full   = out_valid && !out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (ctrl.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (ctrl.out_load) begin
      blue_out <= bt_r; green_out <= gt_r; red_out <= rt_r;
    end
  end

  a_pix_sat: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.acc_write && $past(pix_r) == COUNT_MAX |=> pix_r == COUNT_MAX)
    else $error("pixel count wrapped");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("beat dropped");
  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.bld_write && !pix_zero |-> bquo_r <= 9'd256 || q_ovf)
    else $error("quotient out of range");

endmodule

### hw/rtl/rgb_histogram_equalizer.sv
// ----------------------------------------------------------------------------
// rgb_histogram_equalizer: per-channel 8-bit histogram equalization
// Top level: command sequencer plus histogram/table datapath.
// ----------------------------------------------------------------------------
// Usage: each in_ beat carries a command in in_tuser and a BGR pixel in
// in_tdata. Accumulate counts the pixel. Map looks up the three tables
// and loads the result into the output register, raising out_tvalid, as
// the sequencer returns to idle to take the next command. Build walks all
// 256 bins, each bin taking a read, a running-sum add, 9 serial divider
// steps (one quotient bit per cycle) and a table write.
// Clear sweeps the bin memories one entry a cycle.
// One command is worked on at a time; in_tready is high only when idle.
// Reset clears the pixel counter, controller and output valid, then runs
// a clearing sweep of the bin memories with in_tready low.
// When the receiver stalls, the map result waits in the output register;
// a following map holds the sequencer (and in_tready low) until it loads.
// ----------------------------------------------------------------------------
module rgb_histogram_equalizer import rhe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // blue_in, green_in, red_in
  input  logic [1:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // blue_out, green_out, red_out
);

  ctrl_t ctrl;
  stat_t stat;
  logic  busy, fire;

  assign in_tready = !busy;
  assign fire      = in_tvalid && in_tready;

  rhe_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_fire(fire),
    .in_cmd (cmd_t'(in_tuser)),
    .stat   (stat),
    .busy   (busy),
    .ctrl   (ctrl)
  );

  rhe_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .blue_in  (in_tdata[7:0]),
    .green_in (in_tdata[15:8]),
    .red_in   (in_tdata[23:16]),
    .out_ready(out_tready),
    .out_valid(out_tvalid),
    .blue_out (out_tdata[7:0]),
    .green_out(out_tdata[15:8]),
    .red_out  (out_tdata[23:16]),
    .stat     (stat)
  );

endmodule
